[rtl/core/owe_pkg.sv]
// ----------------------------------------------------------------------------
// owe_pkg: shared definitions for the 1-Wire EEPROM access sequencer
// Function and operation codes, bus command bytes, controller types and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package owe_pkg;

  localparam int ROW_BYTES_DEF = 8;
  // Index field width in the command bundle; covers rows of up to 32 bytes.
  localparam int IDX_W = 5;

  localparam logic [2:0] FUNC_START_W  = 3'd0;
  localparam logic [2:0] FUNC_WDATA    = 3'd1;
  localparam logic [2:0] FUNC_START_R  = 3'd2;
  localparam logic [2:0] FUNC_PRESENCE = 3'd3;
  localparam logic [2:0] FUNC_BUS_BYTE = 3'd4;

  localparam logic [2:0] OP_RESET = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_DATA  = 3'd3;
  localparam logic [2:0] OP_DONE  = 3'd4;
  localparam logic [2:0] OP_ERROR = 3'd5;

  localparam logic [1:0] ERR_RANGE    = 2'd0;
  localparam logic [1:0] ERR_PRESENCE = 2'd1;
  localparam logic [1:0] ERR_STATUS   = 2'd2;

  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_WRITE_SP = 8'h0F;
  localparam logic [7:0] CMD_READ_SP  = 8'hAA;
  localparam logic [7:0] CMD_COPY_SP  = 8'h55;
  localparam logic [7:0] CMD_READ_MEM = 8'hF0;
  localparam logic [7:0] STATUS_OK    = 8'h07;

  localparam logic [15:0] TOP_RESET = 16'h007F;

  typedef enum logic [2:0] {
    P_IDLE, P_WDATA, P_WPRES1, P_WPRES2, P_WSTAT, P_WPRES3, P_RPRES, P_RDATA
  } phase_t;

  typedef enum logic {
    C_IDLE, C_EMIT
  } ctl_state_t;

  typedef enum logic [3:0] {
    Q_ERR, Q_RESET, Q_WROW, Q_RSP, Q_READ, Q_COPY, Q_COPY_DONE, Q_RMEM,
    Q_RDATA_DONE, Q_RDATA_MORE
  } seq_t;

  typedef enum logic [3:0] {
    V_ZERO, V_SKIP, V_WSP, V_RSP, V_COPY, V_RMEM, V_ALO, V_AHI, V_ROW, V_STAT,
    V_BYTE
  } val_sel_t;

  typedef struct packed {
    logic             load_req;
    logic             store_row;
    logic             clr_sidx;
    logic             store_stat;
    logic             copy_adv;
    logic             rd_adv;
    logic             emit;
    logic [2:0]       op;
    val_sel_t         sel;
    logic [IDX_W-1:0] idx;
    logic [1:0]       err;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic range_ok;
    logic row_done;
    logic rem_one;
    logic rem_zero;
    logic stat_last;
    logic stat_ok;
    logic slot_free;
  } dp_sts_t;

endpackage

[rtl/core/owe_datapath.sv]
// ----------------------------------------------------------------------------
// owe_datapath: address, count, row and status storage and result register
// Holds the request state and row buffer, forms each result byte and keeps
// the registered result beat.
// ----------------------------------------------------------------------------
module owe_datapath import owe_pkg::*; #(
  parameter int ROW_BYTES = ROW_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_length,
  input  logic [7:0]  in_data_byte,
  input  logic        cfg_wr,
  input  logic [15:0] cfg_data,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [2:0]  out_op,
  output logic [7:0]  out_value,
  output logic [1:0]  out_error_code,
  output logic        out_last
);

  localparam int FILL_W    = $clog2(ROW_BYTES + 1);
  localparam int ROW_IDX_W = $clog2(ROW_BYTES);

  logic [15:0]          top_r, top_nxt;
  logic [15:0]          addr_r, addr_nxt;
  logic [7:0]           rem_r, rem_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [7:0]           row_r [ROW_BYTES];
  logic [7:0]           stat_r [3];
  logic [1:0]           sidx_r, sidx_nxt;
  logic [7:0]           byte_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [2:0]           out_op_r;
  logic [7:0]           out_value_r, value_nxt;
  logic [1:0]           out_err_r;
  logic                 out_last_r;
  logic [16:0]          end_addr;
  logic [ROW_IDX_W-1:0] row_sel;
  logic [ROW_IDX_W-1:0] wr_sel;
  logic [7:0]           row_val;

  assign end_addr = {1'b0, in_address} + {9'b0, in_length} - 17'd1;
  assign wr_sel   = fill_r[ROW_IDX_W-1:0];

  always_comb begin
    sts.range_ok  = (in_length != 8'd0) && (end_addr <= {1'b0, top_r});
    sts.row_done  = (fill_r == FILL_W'(ROW_BYTES - 1)) || (rem_r == 8'd1);
    sts.rem_one   = (rem_r == 8'd1);
    sts.rem_zero  = (rem_r == 8'd0);
    sts.stat_last = (sidx_r == 2'd2);
    sts.stat_ok   = (in_data_byte == STATUS_OK);
    sts.slot_free = !out_valid_r || out_ready;
  end

  // Row entries past the fill count go out as zero padding.
  assign row_sel = cmd.idx[ROW_IDX_W-1:0];
  assign row_val = (FILL_W'(row_sel) < fill_r) ? row_r[row_sel] : 8'h00;

  always_comb begin
    case (cmd.sel)
      V_SKIP:  value_nxt = CMD_SKIP_ROM;
      V_WSP:   value_nxt = CMD_WRITE_SP;
      V_RSP:   value_nxt = CMD_READ_SP;
      V_COPY:  value_nxt = CMD_COPY_SP;
      V_RMEM:  value_nxt = CMD_READ_MEM;
      V_ALO:   value_nxt = addr_r[7:0];
      V_AHI:   value_nxt = addr_r[15:8];
      V_ROW:   value_nxt = row_val;
      V_STAT:  value_nxt = stat_r[cmd.idx[1:0]];
      V_BYTE:  value_nxt = byte_r;
      default: value_nxt = 8'h00;
    endcase
  end

  always_comb begin
    top_nxt  = cfg_wr ? cfg_data : top_r;
    addr_nxt = addr_r;
    rem_nxt  = rem_r;
    fill_nxt = fill_r;
    sidx_nxt = sidx_r;
    if (cmd.load_req) begin
      addr_nxt = in_address;
      rem_nxt  = in_length;
      fill_nxt = '0;
    end
    if (cmd.store_row) begin
      fill_nxt = fill_r + FILL_W'(1);
      rem_nxt  = rem_r - 8'd1;
    end
    if (cmd.copy_adv) begin
      addr_nxt = addr_r + 16'(ROW_BYTES);
      fill_nxt = '0;
    end
    if (cmd.rd_adv) begin
      addr_nxt = addr_r + 16'd1;
      rem_nxt  = rem_r - 8'd1;
    end
    if (cmd.clr_sidx) begin
      sidx_nxt = 2'd0;
    end else if (cmd.store_stat) begin
      sidx_nxt = sidx_r + 2'd1;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= TOP_RESET;
      addr_r      <= '0;
      rem_r       <= '0;
      fill_r      <= '0;
      sidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      top_r       <= top_nxt;
      addr_r      <= addr_nxt;
      rem_r       <= rem_nxt;
      fill_r      <= fill_nxt;
      sidx_r      <= sidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_row) begin
      row_r[wr_sel] <= in_data_byte;
    end
    if (cmd.store_stat) begin
      stat_r[sidx_r] <= in_data_byte;
    end
    if (cmd.rd_adv) begin
      byte_r <= in_data_byte;
    end
    if (cmd.emit) begin
      out_op_r    <= cmd.op;
      out_value_r <= value_nxt;
      out_err_r   <= cmd.err;
      out_last_r  <= cmd.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_op         = out_op_r;
  assign out_value      = out_value_r;
  assign out_error_code = out_err_r;
  assign out_last       = out_last_r;

endmodule

[rtl/core/owe_ctrl.sv]
// ----------------------------------------------------------------------------
// owe_ctrl: protocol phase tracking and result sequencing
// Decodes each accepted input beat against the protocol phase and steps
// through the resulting bus sequence, one result beat per cycle unless stalled.
// ----------------------------------------------------------------------------
module owe_ctrl import owe_pkg::*; #(
  parameter int ROW_BYTES = ROW_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_func,
  input  logic       in_line_level,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);

  localparam int CNT_W = $clog2(ROW_BYTES + 5);

  ctl_state_t       state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  seq_t             seq_r, seq_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       err_r, err_nxt;

  logic     accept;
  logic     dec_emit;
  seq_t     dec_seq;
  phase_t   dec_phase;
  logic [1:0] dec_err;
  logic     dec_load, dec_store_row, dec_clr_sidx, dec_store_stat;
  logic     dec_copy_adv, dec_rd_adv;

  logic [2:0]       st_op;
  val_sel_t         st_sel;
  logic [IDX_W-1:0] st_idx;
  logic             st_last;

  assign accept = in_valid && (state_r == C_IDLE);

  // Decode of one input beat in the current phase.
  always_comb begin
    dec_emit       = 1'b0;
    dec_seq        = Q_ERR;
    dec_phase      = phase_r;
    dec_err        = ERR_RANGE;
    dec_load       = 1'b0;
    dec_store_row  = 1'b0;
    dec_clr_sidx   = 1'b0;
    dec_store_stat = 1'b0;
    dec_copy_adv   = 1'b0;
    dec_rd_adv     = 1'b0;
    case (in_func)
      FUNC_START_W, FUNC_START_R: begin
        if (!sts.range_ok) begin
          dec_emit  = 1'b1;
          dec_seq   = Q_ERR;
          dec_err   = ERR_RANGE;
          dec_phase = P_IDLE;
        end else begin
          dec_load = 1'b1;
          if (in_func == FUNC_START_W) begin
            dec_phase = P_WDATA;
          end else begin
            dec_emit  = 1'b1;
            dec_seq   = Q_RESET;
            dec_phase = P_RPRES;
          end
        end
      end
      FUNC_WDATA: begin
        if (phase_r == P_WDATA) begin
          dec_store_row = 1'b1;
          if (sts.row_done) begin
            dec_emit  = 1'b1;
            dec_seq   = Q_RESET;
            dec_phase = P_WPRES1;
          end
        end
      end
      FUNC_PRESENCE: begin
        if (phase_r inside {P_WPRES1, P_WPRES2, P_WPRES3, P_RPRES}) begin
          dec_emit = 1'b1;
          if (in_line_level) begin
            dec_seq   = Q_ERR;
            dec_err   = ERR_PRESENCE;
            dec_phase = P_IDLE;
          end else begin
            case (phase_r)
              P_WPRES1: begin
                dec_seq   = Q_WROW;
                dec_phase = P_WPRES2;
              end
              P_WPRES2: begin
                dec_clr_sidx = 1'b1;
                dec_seq      = Q_RSP;
                dec_phase    = P_WSTAT;
              end
              P_WPRES3: begin
                dec_copy_adv = 1'b1;
                if (sts.rem_zero) begin
                  dec_seq   = Q_COPY_DONE;
                  dec_phase = P_IDLE;
                end else begin
                  dec_seq   = Q_COPY;
                  dec_phase = P_WDATA;
                end
              end
              default: begin
                dec_seq   = Q_RMEM;
                dec_phase = P_RDATA;
              end
            endcase
          end
        end
      end
      FUNC_BUS_BYTE: begin
        if (phase_r == P_WSTAT) begin
          dec_store_stat = 1'b1;
          dec_emit       = 1'b1;
          if (!sts.stat_last) begin
            dec_seq = Q_READ;
          end else begin
            dec_clr_sidx = 1'b1;
            if (!sts.stat_ok) begin
              dec_seq   = Q_ERR;
              dec_err   = ERR_STATUS;
              dec_phase = P_IDLE;
            end else begin
              dec_seq   = Q_RESET;
              dec_phase = P_WPRES3;
            end
          end
        end else if (phase_r == P_RDATA) begin
          dec_rd_adv = 1'b1;
          dec_emit   = 1'b1;
          if (sts.rem_one) begin
            dec_seq   = Q_RDATA_DONE;
            dec_phase = P_IDLE;
          end else begin
            dec_seq = Q_RDATA_MORE;
          end
        end
      end
      default: ;
    endcase
  end

  // One step of the running sequence.
  always_comb begin
    st_op   = OP_WRITE;
    st_sel  = V_ZERO;
    st_idx  = '0;
    st_last = 1'b0;
    case (seq_r)
      Q_ERR: begin
        st_op   = OP_ERROR;
        st_last = 1'b1;
      end
      Q_RESET: begin
        st_op   = OP_RESET;
        st_last = 1'b1;
      end
      Q_WROW: begin
        if (cnt_r == CNT_W'(0)) begin
          st_sel = V_SKIP;
        end else if (cnt_r == CNT_W'(1)) begin
          st_sel = V_WSP;
        end else if (cnt_r == CNT_W'(2)) begin
          st_sel = V_ALO;
        end else if (cnt_r == CNT_W'(3)) begin
          st_sel = V_AHI;
        end else if (cnt_r == CNT_W'(ROW_BYTES + 4)) begin
          st_op   = OP_RESET;
          st_last = 1'b1;
        end else begin
          st_sel = V_ROW;
          st_idx = IDX_W'(cnt_r - CNT_W'(4));
        end
      end
      Q_RSP: begin
        if (cnt_r == CNT_W'(0)) begin
          st_sel = V_SKIP;
        end else if (cnt_r == CNT_W'(1)) begin
          st_sel = V_RSP;
        end else begin
          st_op   = OP_READ;
          st_last = 1'b1;
        end
      end
      Q_READ: begin
        st_op   = OP_READ;
        st_last = 1'b1;
      end
      Q_COPY, Q_COPY_DONE: begin
        if (cnt_r == CNT_W'(0)) begin
          st_sel = V_SKIP;
        end else if (cnt_r == CNT_W'(1)) begin
          st_sel = V_COPY;
        end else if (cnt_r == CNT_W'(5)) begin
          st_op   = OP_DONE;
          st_last = 1'b1;
        end else begin
          st_sel  = V_STAT;
          st_idx  = IDX_W'(cnt_r - CNT_W'(2));
          st_last = (seq_r == Q_COPY) && (cnt_r == CNT_W'(4));
        end
      end
      Q_RMEM: begin
        if (cnt_r == CNT_W'(0)) begin
          st_sel = V_SKIP;
        end else if (cnt_r == CNT_W'(1)) begin
          st_sel = V_RMEM;
        end else if (cnt_r == CNT_W'(2)) begin
          st_sel = V_ALO;
        end else if (cnt_r == CNT_W'(3)) begin
          st_sel = V_AHI;
        end else begin
          st_op   = OP_READ;
          st_last = 1'b1;
        end
      end
      Q_RDATA_DONE, Q_RDATA_MORE: begin
        if (cnt_r == CNT_W'(0)) begin
          st_op  = OP_DATA;
          st_sel = V_BYTE;
        end else begin
          st_op   = (seq_r == Q_RDATA_DONE) ? OP_DONE : OP_READ;
          st_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    seq_nxt   = seq_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    case (state_r)
      C_IDLE: begin
        if (in_valid) begin
          phase_nxt = dec_phase;
          if (dec_emit) begin
            state_nxt = C_EMIT;
            seq_nxt   = dec_seq;
            cnt_nxt   = '0;
            err_nxt   = dec_err;
          end
        end
      end
      C_EMIT: begin
        if (sts.slot_free) begin
          if (st_last) begin
            state_nxt = C_IDLE;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == C_IDLE);
    cmd.load_req   = accept && dec_load;
    cmd.store_row  = accept && dec_store_row;
    cmd.clr_sidx   = accept && dec_clr_sidx;
    cmd.store_stat = accept && dec_store_stat;
    cmd.copy_adv   = accept && dec_copy_adv;
    cmd.rd_adv     = accept && dec_rd_adv;
    cmd.emit       = (state_r == C_EMIT) && sts.slot_free;
    cmd.op         = st_op;
    cmd.sel        = st_sel;
    cmd.idx        = st_idx;
    cmd.err        = (seq_r == Q_ERR) ? err_r : ERR_RANGE;
    cmd.last       = st_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      phase_r <= P_IDLE;
      seq_r   <= Q_ERR;
      cnt_r   <= '0;
      err_r   <= ERR_RANGE;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      seq_r   <= seq_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

  a_start_w_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_START_W && sts.range_ok)
      |=> (state_r == C_IDLE && phase_r == P_WDATA))
    else $error("accepted write request did not wait for data");

  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_EMIT && seq_r == Q_ERR) |-> (phase_r == P_IDLE))
    else $error("error sequence with protocol still active");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_EMIT && (seq_r == Q_COPY_DONE || seq_r == Q_RDATA_DONE))
      |-> (phase_r == P_IDLE))
    else $error("done sequence with protocol still active");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_EMIT) |-> (cnt_r <= CNT_W'(ROW_BYTES + 4)))
    else $error("sequence step counter out of range");

endmodule

[rtl/core/one_wire_eeprom_access_sequencer_top.sv]
// ----------------------------------------------------------------------------
// one_wire_eeprom_access_sequencer_top: 1-Wire EEPROM byte command sequencer
// Each input beat is taken while the controller is idle; its results then
// leave one beat per cycle through a registered output stage while the
// output does not stall, and the input stays closed until the last one is
// issued. The longest case is the scratchpad row write, ROW_BYTES + 5
// results, paced by the sequence step counter. Beats that cause no result
// are taken every cycle. The top address register may be written at any
// time the block is idle and is taken in the cycle it is offered.
// ----------------------------------------------------------------------------
module one_wire_eeprom_access_sequencer_top import owe_pkg::*; #(
  parameter int ROW_BYTES = ROW_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_length,
  input  logic [7:0]  in_data_byte,
  input  logic        in_line_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_op,
  output logic [7:0]  out_value,
  output logic [1:0]  out_error_code,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  owe_ctrl #(
    .ROW_BYTES(ROW_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_line_level(in_line_level),
    .sts          (sts),
    .cmd          (cmd)
  );

  owe_datapath #(
    .ROW_BYTES(ROW_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_address    (in_address),
    .in_length     (in_length),
    .in_data_byte  (in_data_byte),
    .cfg_wr        (cfg_valid),
    .cfg_data      (cfg_data),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_op        (out_op),
    .out_value     (out_value),
    .out_error_code(out_error_code),
    .out_last      (out_last)
  );

endmodule

[bench/owe_checker.sv]
// ----------------------------------------------------------------------------
// owe_checker: result predictor and scoreboard for the EEPROM sequencer
// Watches the input, result and top address channels. Every accepted input
// beat runs through a cycle-free copy of the sequencer and its bus
// operations are queued. Each accepted result beat is compared field by
// field with the oldest queued operation.
// ----------------------------------------------------------------------------
module owe_checker import owe_pkg::*; #(
  parameter int ROW_BYTES = ROW_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_length,
  input  logic [7:0]  in_data_byte,
  input  logic        in_line_level,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_op,
  input  logic [7:0]  out_value,
  input  logic [1:0]  out_error_code,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          ops_pending
);

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] value;
    logic [1:0] err;
    logic       last;
  } bus_op_t;

  bus_op_t     op_queue[$];
  logic [15:0] top_addr;
  phase_t      phase;
  logic [15:0] cur_addr;
  logic [7:0]  remaining;
  logic [7:0]  row_buf[ROW_BYTES];
  int          row_fill;
  logic [7:0]  stat_buf[3];
  int          stat_idx;

  function automatic void push_op(logic [2:0] op, logic [7:0] value, logic [1:0] err);
    bus_op_t b;
    b.op = op;
    b.value = value;
    b.err = err;
    b.last = 1'b0;
    op_queue.push_back(b);
  endfunction

  function automatic void fail_to_idle(logic [1:0] err);
    push_op(OP_ERROR, 8'h00, err);
    phase = P_IDLE;
  endfunction

  function automatic void sequence_beat(logic [2:0] func, logic [15:0] addr,
                                        logic [7:0] len, logic [7:0] data, logic absent);
    int   size_at_start;
    logic [16:0] end_addr;
    size_at_start = op_queue.size();
    end_addr = {1'b0, addr} + {9'b0, len} - 17'd1;
    if (func == FUNC_START_W || func == FUNC_START_R) begin
      if (len == 8'd0 || end_addr > {1'b0, top_addr}) begin
        fail_to_idle(ERR_RANGE);
      end else begin
        cur_addr = addr;
        remaining = len;
        row_fill = 0;
        if (func == FUNC_START_W) begin
          phase = P_WDATA;
        end else begin
          push_op(OP_RESET, 8'h00, 2'd0);
          phase = P_RPRES;
        end
      end
    end else if (func == FUNC_WDATA) begin
      if (phase == P_WDATA && row_fill < ROW_BYTES) begin
        row_buf[row_fill] = data;
        row_fill++;
        remaining--;
        if (row_fill >= ROW_BYTES || remaining == 8'd0) begin
          for (int i = row_fill; i < ROW_BYTES; i++) row_buf[i] = 8'h00;
          push_op(OP_RESET, 8'h00, 2'd0);
          phase = P_WPRES1;
        end
      end
    end else if (func == FUNC_PRESENCE) begin
      if (phase inside {P_WPRES1, P_WPRES2, P_WPRES3, P_RPRES}) begin
        if (absent) begin
          fail_to_idle(ERR_PRESENCE);
        end else if (phase == P_WPRES1) begin
          push_op(OP_WRITE, CMD_SKIP_ROM, 2'd0);
          push_op(OP_WRITE, CMD_WRITE_SP, 2'd0);
          push_op(OP_WRITE, cur_addr[7:0], 2'd0);
          push_op(OP_WRITE, cur_addr[15:8], 2'd0);
          for (int i = 0; i < ROW_BYTES; i++) push_op(OP_WRITE, row_buf[i], 2'd0);
          push_op(OP_RESET, 8'h00, 2'd0);
          phase = P_WPRES2;
        end else if (phase == P_WPRES2) begin
          push_op(OP_WRITE, CMD_SKIP_ROM, 2'd0);
          push_op(OP_WRITE, CMD_READ_SP, 2'd0);
          push_op(OP_READ, 8'h00, 2'd0);
          stat_idx = 0;
          phase = P_WSTAT;
        end else if (phase == P_WPRES3) begin
          push_op(OP_WRITE, CMD_SKIP_ROM, 2'd0);
          push_op(OP_WRITE, CMD_COPY_SP, 2'd0);
          for (int i = 0; i < 3; i++) push_op(OP_WRITE, stat_buf[i], 2'd0);
          cur_addr = cur_addr + 16'(ROW_BYTES);
          row_fill = 0;
          if (remaining == 8'd0) begin
            push_op(OP_DONE, 8'h00, 2'd0);
            phase = P_IDLE;
          end else begin
            phase = P_WDATA;
          end
        end else begin
          push_op(OP_WRITE, CMD_SKIP_ROM, 2'd0);
          push_op(OP_WRITE, CMD_READ_MEM, 2'd0);
          push_op(OP_WRITE, cur_addr[7:0], 2'd0);
          push_op(OP_WRITE, cur_addr[15:8], 2'd0);
          push_op(OP_READ, 8'h00, 2'd0);
          phase = P_RDATA;
        end
      end
    end else if (func == FUNC_BUS_BYTE) begin
      if (phase == P_WSTAT) begin
        stat_buf[stat_idx] = data;
        stat_idx++;
        if (stat_idx < 3) begin
          push_op(OP_READ, 8'h00, 2'd0);
        end else begin
          stat_idx = 0;
          if (stat_buf[2] != STATUS_OK) begin
            fail_to_idle(ERR_STATUS);
          end else begin
            push_op(OP_RESET, 8'h00, 2'd0);
            phase = P_WPRES3;
          end
        end
      end else if (phase == P_RDATA) begin
        push_op(OP_DATA, data, 2'd0);
        remaining--;
        cur_addr++;
        if (remaining == 8'd0) begin
          push_op(OP_DONE, 8'h00, 2'd0);
          phase = P_IDLE;
        end else begin
          push_op(OP_READ, 8'h00, 2'd0);
        end
      end
    end
    if (op_queue.size() > size_at_start) op_queue[op_queue.size() - 1].last = 1'b1;
  endfunction

  assign ops_pending = op_queue.size();

  always @(posedge clk) begin
    bus_op_t got;
    bus_op_t want;
    if (!rst_n) begin
      op_queue.delete();
      top_addr <= TOP_RESET;
      phase = P_IDLE;
      cur_addr = '0;
      remaining = '0;
      row_fill = 0;
      stat_idx = 0;
    end else begin
      if (cfg_valid && cfg_ready) top_addr <= cfg_data;
      if (in_valid && in_ready)
        sequence_beat(in_func, in_address, in_length, in_data_byte, in_line_level);
      if (out_valid && out_ready) begin
        got = '{out_op, out_value, out_error_code, out_last};
        if (op_queue.size() == 0) begin
          $display("%0t: unexpected result beat op %0d value %h err %0d last %0d",
                   $time, got.op, got.value, got.err, got.last);
          fail_count++;
        end else begin
          want = op_queue.pop_front();
          if (got != want) begin
            $display("%0t: result mismatch, expected op %0d value %h err %0d last %0d,",
                     $time, want.op, want.value, want.err, want.last);
            $display("%0t:   actual op %0d value %h err %0d last %0d",
                     $time, got.op, got.value, got.err, got.last);
            fail_count++;
          end
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the 1-Wire EEPROM access sequencer
// Drives directed corner cases, then well-formed write and read sessions
// with random content mixed with broken sessions and noise, over several
// top address settings. The checker beside the block scores every result.
// ----------------------------------------------------------------------------
module tb_top import owe_pkg::*;;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_func;
  logic [15:0] in_address;
  logic [7:0]  in_length;
  logic [7:0]  in_data_byte;
  logic        in_line_level;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_op;
  logic [7:0]  out_value;
  logic [1:0]  out_error_code;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  int          fail_count;
  int          ops_pending;
  int          cycles;
  int          beats_sent;
  logic [15:0] top_now;
  logic        calm;

  one_wire_eeprom_access_sequencer_top u_top (.*);

  owe_checker u_check (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // The result side stalls on its own schedule.
  always @(posedge clk) out_ready <= calm || ($urandom_range(0, 99) >= 8);

  function automatic logic r1();
    return 1'($urandom);
  endfunction

  function automatic logic [2:0] r3();
    return 3'($urandom);
  endfunction

  function automatic logic [7:0] r8();
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] r16();
    return 16'($urandom);
  endfunction

  task automatic send(logic [2:0] f, logic [15:0] a, logic [7:0] l,
                      logic [7:0] d, logic lv);
    if (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_address <= a;
    in_length <= l;
    in_data_byte <= d;
    in_line_level <= lv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // Waits for the block to drain before the top address changes.
  task automatic set_top(logic [15:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (ops_pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    top_now = v;
  endtask

  // Scratchpad write session; a nonzero break_at that the session reaches cuts it short with a fault.
  task automatic write_session(logic [15:0] a, logic [7:0] l, int break_at);
    int left;
    int n;
    int step;
    step = 0;
    left = int'(l);
    send(FUNC_START_W, a, l, r8(), r1());
    while (left > 0) begin
      n = (left > ROW_BYTES_DEF) ? ROW_BYTES_DEF : left;
      repeat (n) send(FUNC_WDATA, r16(), r8(), r8(), r1());
      left -= n;
      step++;
      send(FUNC_PRESENCE, r16(), r8(), r8(), step == break_at);
      if (step == break_at) return;
      send(FUNC_PRESENCE, r16(), r8(), r8(), 1'b0);
      send(FUNC_BUS_BYTE, r16(), r8(), r8(), r1());
      send(FUNC_BUS_BYTE, r16(), r8(), r8(), r1());
      step++;
      send(FUNC_BUS_BYTE, r16(), r8(),
           (step == break_at) ? 8'(~STATUS_OK) : STATUS_OK, r1());
      if (step == break_at) return;
      send(FUNC_PRESENCE, r16(), r8(), r8(), 1'b0);
    end
  endtask

  task automatic read_session(logic [15:0] a, logic [7:0] l, logic absent);
    send(FUNC_START_R, a, l, r8(), r1());
    send(FUNC_PRESENCE, r16(), r8(), r8(), absent);
    if (!absent) repeat (l) send(FUNC_BUS_BYTE, r16(), r8(), r8(), r1());
  endtask

  task automatic random_traffic(int quota);
    int        lim;
    int        pick;
    logic [7:0] l;
    logic [15:0] a;
    while (beats_sent < quota) begin
      lim = (top_now > 16'd20) ? 20 : int'(top_now) + 1;
      l = 8'($urandom_range(1, lim));
      a = 16'($urandom_range(0, int'(top_now) - int'(l) + 1));
      pick = int'($urandom_range(0, 99));
      if (pick < 40)
        write_session(a, l, ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, 4)) : 0);
      else if (pick < 75) read_session(a, l, $urandom_range(0, 9) == 0);
      else if (pick < 85) send(FUNC_START_R, r16(), r8(), r8(), r1());
      else send(r3(), r16(), r8(), r8(), r1());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_START_W;
    in_address = '0;
    in_length = '0;
    in_data_byte = '0;
    in_line_level = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cycles = 0;
    beats_sent = 0;
    calm = 1'b0;
    top_now = TOP_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Rejections, ignored beats and out-of-phase beats at reset settings.
    send(FUNC_START_W, 16'h0000, 8'd0, 8'h00, 1'b0);
    send(FUNC_START_R, 16'h0001, 8'd128, 8'hFF, 1'b1);
    send(3'd5, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
    send(3'd6, 16'h0000, 8'h00, 8'h00, 1'b0);
    send(3'd7, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
    send(FUNC_WDATA, 16'h0000, 8'd1, 8'hA5, 1'b0);
    send(FUNC_PRESENCE, 16'h0000, 8'd1, 8'h00, 1'b0);
    send(FUNC_BUS_BYTE, 16'h0000, 8'd1, 8'h5A, 1'b0);
    read_session(16'h0000, 8'd1, 1'b1);
    read_session(16'h007E, 8'd2, 1'b0);
    write_session(16'h0010, 8'd1, 2);
    // A new request abandons the one in flight.
    send(FUNC_START_W, 16'h0020, 8'd4, 8'h00, 1'b0);
    write_session(16'h0078, 8'd3, 0);
    random_traffic(50);

    set_top(16'hFFFF);
    calm = 1'b1;
    write_session(16'hFFF8, 8'd8, 0);
    read_session(16'hFFFF, 8'd1, 1'b0);
    random_traffic(80);
    calm = 1'b0;

    set_top(16'h0000);
    send(FUNC_START_R, 16'h0000, 8'd2, 8'h00, 1'b0);
    read_session(16'h0000, 8'd1, 1'b0);
    write_session(16'h0000, 8'd1, 0);
    random_traffic(100);

    set_top(16'($urandom_range(30, 1000)));
    random_traffic(120);

    in_valid <= 1'b0;
    @(posedge clk);
    while (ops_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
